// File: src/gtg_pkg.sv
package gtg_pkg;

   localparam int XY_W   = 28;   // CORDIC x/y datapath, covers prescale and gain growth
   localparam int ANG_W  = 20;   // Q.16 angle
   localparam int ERR_W  = 21;   // heading error before wrap
   localparam int DIST_W = 17;   // distance, Q.10
   localparam int MA_W   = 28;   // multiplier operand a
   localparam int MB_W   = 17;   // multiplier operand b
   localparam int MP_W   = MA_W + MB_W;
   localparam int SH_W   = 5;    // shift amount / arctangent table index
   localparam int ATAN_W = 16;
   localparam int MAX_ITER = 24;

   localparam int PRESCALE = 8;
   localparam logic signed [ANG_W-1:0] PI_Q16     = 20'sd205887;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q16 = 21'sd411775;
   localparam logic signed [MB_W-1:0]  INV_K_Q16  = 17'sd39797;
   localparam logic [19:0]             LIN_MAX    = 20'hFFFFF;
   localparam logic signed [18:0]      TURN_MAX   = 19'sd262143;
   localparam logic signed [18:0]      TURN_MIN   = -19'sd262144;

   localparam logic [2:0] REG_GOAL_X      = 3'd0;
   localparam logic [2:0] REG_GOAL_Y      = 3'd1;
   localparam logic [2:0] REG_TOLERANCE   = 3'd2;
   localparam logic [2:0] REG_LINEAR_GAIN = 3'd3;
   localparam logic [2:0] REG_ANGULAR_GAIN = 3'd4;

   typedef logic signed [XY_W-1:0]  xy_type;
   typedef logic signed [ANG_W-1:0] ang_type;

   typedef struct packed {
      xy_type  x;
      xy_type  y;
      ang_type z;
   } cordic_vec_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_ITER = 8'b0000_0010,
      ST_MULD = 8'b0000_0100,
      ST_CHK  = 8'b0000_1000,
      ST_WRAP = 8'b0001_0000,
      ST_MULL = 8'b0010_0000,
      ST_MULT = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   // round(atan(2^-i) * 2^16)
   function automatic logic [ATAN_W-1:0] atan_lut(input logic [SH_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:  v = 16'd51472;
         5'd1:  v = 16'd30386;
         5'd2:  v = 16'd16055;
         5'd3:  v = 16'd8150;
         5'd4:  v = 16'd4091;
         5'd5:  v = 16'd2047;
         5'd6:  v = 16'd1024;
         5'd7:  v = 16'd512;
         5'd8:  v = 16'd256;
         5'd9:  v = 16'd128;
         5'd10: v = 16'd64;
         5'd11: v = 16'd32;
         5'd12: v = 16'd16;
         5'd13: v = 16'd8;
         5'd14: v = 16'd4;
         5'd15: v = 16'd2;
         5'd16: v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

// File: src/gtg_cordic_step.sv
module gtg_cordic_step (
   input  gtg_pkg::cordic_vec_type    vec_i,
   input  logic [gtg_pkg::SH_W-1:0]   shift_i,
   output gtg_pkg::cordic_vec_type    vec_o
);

   gtg_pkg::xy_type  xs;
   gtg_pkg::xy_type  ys;
   gtg_pkg::ang_type step;

   assign xs   = vec_i.x >>> shift_i;
   assign ys   = vec_i.y >>> shift_i;
   assign step = gtg_pkg::ang_type'(gtg_pkg::atan_lut(shift_i));

   always_comb begin
      if (vec_i.y > 0) begin
         vec_o.x = vec_i.x + ys;
         vec_o.y = vec_i.y - xs;
         vec_o.z = vec_i.z + step;
      end else begin
         vec_o.x = vec_i.x - ys;
         vec_o.y = vec_i.y + xs;
         vec_o.z = vec_i.z - step;
      end
   end

endmodule

// File: src/gtg_mul.sv
module gtg_mul (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [gtg_pkg::MA_W-1:0]     a,
   input  logic signed [gtg_pkg::MB_W-1:0]     b,
   output logic signed [gtg_pkg::MP_W-1:0]     p
);

   logic signed [gtg_pkg::MP_W-1:0] p_ff;
   logic signed [gtg_pkg::MP_W-1:0] p_in;

   assign p_in = en ? (gtg_pkg::MP_W'(a) * gtg_pkg::MP_W'(b)) : p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

// File: src/go_to_goal_steering_controller.sv
// Go-to-goal steering controller.
// Request channel (req_valid/req_stall) takes one pose sample: pose_x, pose_y
// (Q6.10) and heading (Q3.12 rad). The response channel (rsp_valid/rsp_stall)
// returns linear_speed (Q10.10), turn_rate (Q7.12) and the arrived flag.
// Goal, tolerance and gains are written through csr_valid/csr_ready with a
// register index; csr_ready is always high, and writes belong in idle time.
// The heading error is wrapped into range when needed; a zero vector skips
// the iterations.
// The CORDIC vectoring loop runs one micro-rotation per cycle through one
// shared add/shift stage, then one shared 28x17 multiplier serves distance,
// linear speed and turn rate in turn. A new request is taken only after the
// previous one has been written into the output register.
// Once arrived is latched, a taken request skips the datapath and goes
// straight to the finish state, which returns zeros.
// req_stall is high while a request is in work. A finished response sits in
// an output register; the next request is accepted even while the receiver
// stalls, and its result waits until the held response is taken.
// Reset clears the registers to their defaults, drops the arrived latch and
// empties the output register.
module go_to_goal_steering_controller #(
   parameter int CORDIC_ITERATIONS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_pose_x,
   input  logic signed [15:0] req_pose_y,
   input  logic signed [14:0] req_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [19:0]        rsp_linear_speed,
   output logic signed [18:0] rsp_turn_rate,
   output logic               rsp_arrived,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int NITER  = (CORDIC_ITERATIONS > gtg_pkg::MAX_ITER) ?
                           gtg_pkg::MAX_ITER : CORDIC_ITERATIONS;
   localparam int ITER_W = (NITER > 1) ? $clog2(NITER) : 1;
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(NITER - 1);

   // configuration
   logic signed [15:0] goal_x_ff, goal_x_in;
   logic signed [15:0] goal_y_ff, goal_y_in;
   logic [15:0]        tol_ff, tol_in;
   logic [11:0]        lin_gain_ff, lin_gain_in;
   logic [11:0]        ang_gain_ff, ang_gain_in;

   // control
   gtg_pkg::state_type state_ff, state_in;
   logic [ITER_W-1:0]  cnt_ff, cnt_in;
   logic               reached_ff, reached_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   gtg_pkg::cordic_vec_type          vec_ff, vec_in, vec_step;
   logic signed [14:0]               hd_ff, hd_in;
   logic [gtg_pkg::DIST_W-1:0]       dist_ff, dist_in;
   logic signed [gtg_pkg::ERR_W-1:0] err_ff, err_in;
   logic [19:0]                      lin_ff, lin_in;
   logic [19:0]                      out_lin_ff, out_lin_in;
   logic signed [18:0]               out_turn_ff, out_turn_in;
   logic                             out_arr_ff, out_arr_in;

   // shared multiplier
   logic                              mul_en;
   logic signed [gtg_pkg::MA_W-1:0]   mul_a;
   logic signed [gtg_pkg::MB_W-1:0]   mul_b;
   logic signed [gtg_pkg::MP_W-1:0]   mul_p;

   // load-time values
   logic signed [16:0]              dx, dy;
   gtg_pkg::xy_type                 x0, y0;
   logic signed [gtg_pkg::MP_W-1:0] dist_sum;
   logic [29:0]                     lin_sum;
   logic [21:0]                     lin_full;
   logic signed [33:0]              turn_sum;
   logic signed [21:0]              turn_full;
   logic signed [18:0]              turn_sat;
   logic                            req_take;
   logic                            rsp_take;

   gtg_cordic_step u_step (
      .vec_i   (vec_ff),
      .shift_i (gtg_pkg::SH_W'(cnt_ff)),
      .vec_o   (vec_step)
   );

   gtg_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != gtg_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign dx = 17'(goal_x_ff) - 17'(req_pose_x);
   assign dy = 17'(goal_y_ff) - 17'(req_pose_y);
   assign x0 = gtg_pkg::xy_type'(dx) <<< gtg_pkg::PRESCALE;
   assign y0 = gtg_pkg::xy_type'(dy) <<< gtg_pkg::PRESCALE;

   // distance = (x * 1/K + 2^23) >> 24, x known non-negative
   assign dist_sum = mul_p + gtg_pkg::MP_W'(64'd8388608);
   // linear = (dist * gain + 128) >> 8
   assign lin_sum  = mul_p[29:0] + 30'd128;
   assign lin_full = lin_sum[29:8];
   // turn = floor((err * gain + 2048) / 4096)
   assign turn_sum  = mul_p[33:0] + 34'sd2048;
   assign turn_full = turn_sum[33:12];

   always_comb begin
      if (turn_full > 22'(gtg_pkg::TURN_MAX)) begin
         turn_sat = gtg_pkg::TURN_MAX;
      end else if (turn_full < 22'(gtg_pkg::TURN_MIN)) begin
         turn_sat = gtg_pkg::TURN_MIN;
      end else begin
         turn_sat = turn_full[18:0];
      end
   end

   // configuration writes
   always_comb begin
      goal_x_in   = goal_x_ff;
      goal_y_in   = goal_y_ff;
      tol_in      = tol_ff;
      lin_gain_in = lin_gain_ff;
      ang_gain_in = ang_gain_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gtg_pkg::REG_GOAL_X:       goal_x_in   = csr_wdata;
            gtg_pkg::REG_GOAL_Y:       goal_y_in   = csr_wdata;
            gtg_pkg::REG_TOLERANCE:    tol_in      = csr_wdata;
            gtg_pkg::REG_LINEAR_GAIN:  lin_gain_in = csr_wdata[11:0];
            gtg_pkg::REG_ANGULAR_GAIN: ang_gain_in = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // multiplier operand select
   always_comb begin
      mul_en = 1'b0;
      mul_a  = vec_ff.x;
      mul_b  = gtg_pkg::INV_K_Q16;
      case (state_ff)
         gtg_pkg::ST_MULD: begin
            mul_en = 1'b1;
            mul_a  = (vec_ff.x < 0) ? '0 : vec_ff.x;
            mul_b  = gtg_pkg::INV_K_Q16;
         end
         gtg_pkg::ST_MULL: begin
            mul_en = 1'b1;
            mul_a  = gtg_pkg::MA_W'(dist_ff);
            mul_b  = gtg_pkg::MB_W'(lin_gain_ff);
         end
         gtg_pkg::ST_MULT: begin
            mul_en = 1'b1;
            mul_a  = gtg_pkg::MA_W'(err_ff);
            mul_b  = gtg_pkg::MB_W'(ang_gain_ff);
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      reached_in   = reached_ff;
      vec_in       = vec_ff;
      hd_in        = hd_ff;
      dist_in      = dist_ff;
      err_in       = err_ff;
      lin_in       = lin_ff;
      out_lin_in   = out_lin_ff;
      out_turn_in  = out_turn_ff;
      out_arr_in   = out_arr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;

      case (state_ff)
         gtg_pkg::ST_IDLE: begin
            if (req_take) begin
               hd_in  = req_heading;
               cnt_in = '0;
               vec_in.x = x0;
               vec_in.y = y0;
               vec_in.z = '0;
               if (reached_ff) begin
                  state_in = gtg_pkg::ST_FIN;
               end else if (dx == 0 && dy == 0) begin
                  vec_in.x = '0;
                  state_in = gtg_pkg::ST_MULD;
               end else begin
                  // left half plane: pre-rotate by pi
                  if (dx < 0) begin
                     vec_in.x = -x0;
                     vec_in.y = -y0;
                     vec_in.z = (dy >= 0) ? gtg_pkg::PI_Q16 : -gtg_pkg::PI_Q16;
                  end
                  state_in = gtg_pkg::ST_ITER;
               end
            end
         end
         gtg_pkg::ST_ITER: begin
            vec_in = vec_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ITER) begin
               state_in = gtg_pkg::ST_MULD;
            end
         end
         gtg_pkg::ST_MULD: begin
            state_in = gtg_pkg::ST_CHK;
         end
         gtg_pkg::ST_CHK: begin
            dist_in = dist_sum[40:24];
            err_in  = gtg_pkg::ERR_W'(vec_ff.z) - (gtg_pkg::ERR_W'(hd_ff) <<< 4);
            if (dist_sum[40:24] < gtg_pkg::DIST_W'(tol_ff)) begin
               reached_in = 1'b1;
               state_in   = gtg_pkg::ST_FIN;
            end else begin
               state_in = gtg_pkg::ST_WRAP;
            end
         end
         gtg_pkg::ST_WRAP: begin
            if (err_ff > gtg_pkg::ERR_W'(gtg_pkg::PI_Q16)) begin
               err_in = err_ff - gtg_pkg::TWO_PI_Q16;
            end else if (err_ff < -gtg_pkg::ERR_W'(gtg_pkg::PI_Q16)) begin
               err_in = err_ff + gtg_pkg::TWO_PI_Q16;
            end else begin
               state_in = gtg_pkg::ST_MULL;
            end
         end
         gtg_pkg::ST_MULL: begin
            state_in = gtg_pkg::ST_MULT;
         end
         gtg_pkg::ST_MULT: begin
            lin_in   = (lin_full[21:20] != 2'b00) ? gtg_pkg::LIN_MAX : lin_full[19:0];
            state_in = gtg_pkg::ST_FIN;
         end
         gtg_pkg::ST_FIN: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               if (reached_ff) begin
                  out_lin_in  = '0;
                  out_turn_in = '0;
                  out_arr_in  = 1'b1;
               end else begin
                  out_lin_in  = lin_ff;
                  out_turn_in = turn_sat;
                  out_arr_in  = 1'b0;
               end
               state_in = gtg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gtg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gtg_pkg::ST_IDLE;
         cnt_ff       <= '0;
         reached_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         tol_ff       <= 16'd102;
         lin_gain_ff  <= 12'd384;
         ang_gain_ff  <= 12'd512;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         reached_ff   <= reached_in;
         rsp_valid_ff <= rsp_valid_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         tol_ff       <= tol_in;
         lin_gain_ff  <= lin_gain_in;
         ang_gain_ff  <= ang_gain_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff      <= vec_in;
      hd_ff       <= hd_in;
      dist_ff     <= dist_in;
      err_ff      <= err_in;
      lin_ff      <= lin_in;
      out_lin_ff  <= out_lin_in;
      out_turn_ff <= out_turn_in;
      out_arr_ff  <= out_arr_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_linear_speed = out_lin_ff;
   assign rsp_turn_rate    = out_turn_ff;
   assign rsp_arrived      = out_arr_ff;

endmodule

// File: src/gtg_checker.sv
module gtg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [19:0]        rsp_linear_speed,
   input logic signed [18:0] rsp_turn_rate,
   input logic               rsp_arrived
);

   // no response straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_linear_speed) &&
         $stable(rsp_turn_rate) && $stable(rsp_arrived))
      else $error("stalled response changed");

   // an accepted request keeps the block busy next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   // arrived responses carry zero speeds
   a_arrived_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arrived |-> rsp_linear_speed == 20'd0 && rsp_turn_rate == 19'sd0)
      else $error("nonzero speed with arrived set");

endmodule

bind go_to_goal_steering_controller gtg_checker u_gtg_checker (.*);
